// ----- hdl/wbps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern search block.
// No dependencies; every other file but wbps_req_if imports this package.
package wbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 32;
   localparam int OFFSET_BITS_DEF       = 32;

   localparam int PATTERN_REG_BYTES = 32;   // bytes backed by pattern registers
   localparam int PAT_IDX_W         = 5;    // index into those bytes
   localparam int WORD_W            = 64;
   localparam int N_WORDS           = 4;
   localparam int MASK_W            = 32;
   localparam int LEN_REG_W         = 6;
   localparam int USED_LEN_W        = 7;    // holds a length up to 127
   localparam int CSR_INDEX_W       = 3;
   localparam int OFFSET_OUT_W      = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5
   } wbps_csr_index_type;

   // Control broadcast to every cell of the window chain.
   typedef struct packed {
      logic shift;   // take the neighbor's byte
      logic load;    // take a new aligned pattern byte and care bit
   } wbps_cell_ctl_type;

endpackage

// ----- hdl/wbps_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: one buffer byte per transfer with an end-of-buffer mark.
// Has no dependencies; it does not import wbps_pkg.
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/wbps_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: search outcome for one buffer.
// Depends on wbps_pkg for the offset width.
interface wbps_rsp_if
   import wbps_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [OFFSET_OUT_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ----- hdl/wbps_csr_if.sv -----
`timescale 1ns / 1ps
// Register write channel: register index and 64-bit write data.
// Depends on wbps_pkg for the index and data widths.
interface wbps_csr_if
   import wbps_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/wildcard_byte_pattern_search.sv -----
`timescale 1ns / 1ps
// Wildcard byte pattern search. Streams a buffer one request (one byte) per cycle
// when requests are not held, and reports once per buffer: at the first position
// where the newest pattern_length bytes match the configured pattern (with found
// set and the start offset of the match), or at the byte marked last with found
// cleared and offset 0. Pattern bytes whose care bit is clear match any byte.
// After a match, the remaining bytes of the buffer are taken and dropped until the
// last byte. Throughput is one request per cycle while requests are not held: the
// byte window is a chain of cells that each compare the byte they are about to
// hold against their aligned pattern byte, so the whole window is checked in the
// cycle the byte arrives, and the response lands in an output register. A register
// write holds requests in the following cycle while the cells reload their aligned
// pattern bytes; the same reload runs in the first cycle after reset.
// Depends on wbps_pkg, the three channel interfaces, wbps_cfg and wbps_cell.
module wildcard_byte_pattern_search
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wbps_req_if.sink   req_port,
   wbps_rsp_if.source rsp_port,
   wbps_csr_if.sink   csr_port
);

   // Configuration and alignment
   logic                  cfg_load;
   logic [USED_LEN_W-1:0] used_len;
   logic [7:0]            cell_want [MAX_PATTERN_BYTES];
   logic                  cell_care [MAX_PATTERN_BYTES];

   // Window chain
   wbps_cell_ctl_type        cell_ctl;
   logic [7:0]               chain_in  [MAX_PATTERN_BYTES];
   logic [7:0]               chain_out [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] cell_hit;

   // Stream state
   logic [OFFSET_BITS-1:0]  seen_ff;
   logic [OFFSET_BITS-1:0]  seen_in;
   logic                    reported_ff;
   logic                    req_accept;
   logic                    work;
   logic                    match;
   logic [OFFSET_BITS-1:0]  len_ext;
   logic [OFFSET_BITS-1:0]  start_offset;
   logic                    emit;

   // Response register
   logic                    rsp_valid_ff;
   logic                    found_ff;
   logic [OFFSET_OUT_W-1:0] offset_ff;

   // Register writes are always taken.
   assign csr_port.ready = 1'b1;

   wbps_cfg #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_port.valid && csr_port.ready),
      .wr_index  (csr_port.index),
      .wr_data   (csr_port.data),
      .load      (cfg_load),
      .used_len  (used_len),
      .cell_want (cell_want),
      .cell_care (cell_care)
   );

   // Hold requests in reset, while the cells reload, or while a response is stuck.
   assign req_port.ready = !reset && !cfg_load && (!rsp_valid_ff || rsp_port.ready);
   assign req_accept     = req_port.valid && req_port.ready;
   // Bytes after a report are dropped without touching the window.
   assign work           = req_accept && !reported_ff;

   assign cell_ctl.shift = work;
   assign cell_ctl.load  = cfg_load;

   // Cell 0 takes the incoming byte; every other cell takes its neighbor's.
   always_comb begin
      chain_in[0] = req_port.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         chain_in[k] = chain_out[k-1];
      end
   end

   for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cell
      wbps_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .byte_in  (chain_in[g]),
         .want_in  (cell_want[g]),
         .care_in  (cell_care[g]),
         .byte_out (chain_out[g]),
         .hit      (cell_hit[g])
      );
   end

   // Advance the byte count, saturating at its top value.
   assign seen_in = (seen_ff == '1) ? seen_ff : seen_ff + OFFSET_BITS'(1);
   assign len_ext = OFFSET_BITS'(used_len);

   // Cells beyond the pattern carry a clear care bit, so only the window
   // that holds enough bytes of this buffer can match.
   assign match        = (seen_in >= len_ext) && (&cell_hit);
   assign start_offset = seen_in - len_ext;
   assign emit         = work && (match || req_port.last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (req_accept) begin
         if (req_port.last_byte) begin
            // end of buffer: ready for the next one
            seen_ff     <= '0;
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            seen_ff     <= seen_in;
            reported_ff <= match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         found_ff  <= match;
         offset_ff <= match ? OFFSET_OUT_W'(start_offset) : '0;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.found        = found_ff;
   assign rsp_port.match_offset = offset_ff;

endmodule

// ----- hdl/wbps_cell.sv -----
`timescale 1ns / 1ps
// One window cell: holds one buffer byte plus its aligned pattern byte and care bit.
// Depends on wbps_pkg for the cell control struct.
module wbps_cell
   import wbps_pkg::*;
(
   input  logic              clock,
   input  wbps_cell_ctl_type ctl,
   input  logic [7:0]        byte_in,
   input  logic [7:0]        want_in,
   input  logic              care_in,
   output logic [7:0]        byte_out,
   output logic              hit
);

   logic [7:0] byte_ff;
   logic [7:0] want_ff;
   logic       care_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= byte_in;
      end
      if (ctl.load) begin
         want_ff <= want_in;
         care_ff <= care_in;
      end
   end

   // Compare the byte this cell will hold after the shift.
   assign hit      = !care_ff || (byte_in == want_ff);
   assign byte_out = byte_ff;

endmodule

// ----- hdl/wbps_cfg.sv -----
`timescale 1ns / 1ps
// Register file and pattern alignment: maps pattern bytes onto window cells.
// Depends on wbps_pkg for register codes and widths.
module wbps_cfg
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [WORD_W-1:0]     wr_data,
   output logic                  load,
   output logic [USED_LEN_W-1:0] used_len,
   output logic [7:0]            cell_want [MAX_PATTERN_BYTES],
   output logic                  cell_care [MAX_PATTERN_BYTES]
);

   logic [WORD_W-1:0]    pattern_ff [N_WORDS];
   logic [MASK_W-1:0]    care_mask_ff;
   logic [LEN_REG_W-1:0] length_ff;
   logic                 load_ff;
   logic [7:0]           pat_bytes [PATTERN_REG_BYTES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < N_WORDS; w++) begin
            pattern_ff[w] <= '0;
         end
         care_mask_ff <= '1;
         length_ff    <= LEN_REG_W'(PATTERN_REG_BYTES);
         load_ff      <= 1'b1;
      end else begin
         // realign the cells in the cycle after any write
         load_ff <= wr_en;
         if (wr_en) begin
            unique case (wr_index)
               CSR_PATTERN_WORD_0: pattern_ff[0] <= wr_data;
               CSR_PATTERN_WORD_1: pattern_ff[1] <= wr_data;
               CSR_PATTERN_WORD_2: pattern_ff[2] <= wr_data;
               CSR_PATTERN_WORD_3: pattern_ff[3] <= wr_data;
               CSR_CARE_MASK:      care_mask_ff  <= wr_data[MASK_W-1:0];
               CSR_PATTERN_LENGTH: length_ff     <= wr_data[LEN_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign load = load_ff;

   // Clamp the length into 1..MAX_PATTERN_BYTES.
   always_comb begin
      if (length_ff == '0) begin
         used_len = USED_LEN_W'(1);
      end else if (USED_LEN_W'(length_ff) > USED_LEN_W'(MAX_PATTERN_BYTES)) begin
         used_len = USED_LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         used_len = USED_LEN_W'(length_ff);
      end
   end

   always_comb begin
      for (int w = 0; w < N_WORDS; w++) begin
         for (int b = 0; b < WORD_W / 8; b++) begin
            pat_bytes[w * (WORD_W / 8) + b] = pattern_ff[w][b*8 +: 8];
         end
      end
   end

   // Cell k holds the byte that pattern byte used_len-1-k must match.
   always_comb begin
      logic [USED_LEN_W-1:0] idx;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         idx          = used_len - USED_LEN_W'(k) - USED_LEN_W'(1);
         cell_want[k] = 8'h00;
         cell_care[k] = 1'b0;
         if (USED_LEN_W'(k) < used_len) begin
            if (idx < USED_LEN_W'(PATTERN_REG_BYTES)) begin
               cell_want[k] = pat_bytes[idx[PAT_IDX_W-1:0]];
               cell_care[k] = care_mask_ff[idx[PAT_IDX_W-1:0]];
            end
         end
      end
   end

endmodule

// ----- hdl/wbps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for wildcard_byte_pattern_search, attached by bind.
// Depends on wbps_pkg for the offset width.
module wbps_checker
   import wbps_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_found,
   input logic [OFFSET_OUT_W-1:0] rsp_match_offset,
   input logic                    csr_valid,
   input logic                    csr_ready
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_offset))
      else $error("response changed while stalled");

   // A miss reports offset zero.
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("miss with nonzero offset");

   // A new response only follows an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("response without request");

   // A register write blocks requests for the following cycle.
   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request taken during pattern reload");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_found        (rsp_port.found),
   .rsp_match_offset (rsp_port.match_offset),
   .csr_valid        (csr_port.valid),
   .csr_ready        (csr_port.ready)
);

// ----- test/wildcard_byte_pattern_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_search: directed table, then random buffers.
// Depends on wbps_pkg, the three channel interfaces and the block itself.
module wildcard_byte_pattern_search_tb
   import wbps_pkg::*;
   ;

   localparam int WIN_BYTES    = MAX_PATTERN_BYTES_DEF;
   localparam int DRAIN_CYCLES = 4;      // response register plus reload cycle, with margin
   localparam int PER_SETTING  = 105;    // byte requests per register setting
   localparam int LIMIT_NS     = 400_000;

   // Indexes the block has no register for; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_OUT_W-1:0] offset;
   } scan_outcome_type;

   // One row of the directed table: a register write or one byte request,
   // optionally with the outcome typed in by hand.
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [WORD_W-1:0]      data;
      logic [7:0]             value;
      logic                   last;
      bit                     typed;
      scan_outcome_type       outcome;
   } stim_row_type;

   logic clock;
   logic reset;

   wbps_req_if req_if ();
   wbps_rsp_if rsp_if ();
   wbps_csr_if csr_if ();

   wildcard_byte_pattern_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Predicted register contents.
   logic [WORD_W-1:0]    pattern_words [N_WORDS];
   logic [MASK_W-1:0]    care_bits;
   logic [LEN_REG_W-1:0] length_reg;

   // Predicted stream state: window[0] holds the newest byte.
   logic [7:0]  window [WIN_BYTES];
   logic [31:0] bytes_seen;
   bit          stream_done;

   scan_outcome_type pending_outcomes [$];
   stim_row_type     directed_rows [$];

   int errors         = 0;
   int directed_bytes = 0;
   int random_bytes   = 0;
   int dropped_bytes  = 0;
   int csr_writes     = 0;
   int outcomes_seen  = 0;
   int matches_seen   = 0;
   int send_idle_pct  = 32;
   int recv_idle_pct  = 50;

   // 2 ns period: high for 1 ns, low for 1 ns.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void clear_stream();
      for (int k = 0; k < WIN_BYTES; k++) window[k] = 8'h00;
      bytes_seen  = '0;
      stream_done = 1'b0;
   endfunction

   // Length in use: zero counts as one, anything past the window is clipped.
   function automatic int effective_length();
      int n;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > WIN_BYTES) n = WIN_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(input int i);
      return pattern_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [WORD_W-1:0] data);
      unique case (idx)
         CSR_PATTERN_WORD_0, CSR_PATTERN_WORD_1,
         CSR_PATTERN_WORD_2, CSR_PATTERN_WORD_3: pattern_words[idx[1:0]] = data;
         CSR_CARE_MASK:      care_bits  = data[MASK_W-1:0];
         CSR_PATTERN_LENGTH: length_reg = data[LEN_REG_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the stream by one byte; taken is low when the byte is dropped
   // because this buffer has already been reported.
   function automatic void scan_byte(input logic [7:0] value, input logic last,
                                     output bit taken, output bit has_outcome,
                                     output scan_outcome_type outcome);
      int  len;
      bit  hit;
      taken       = 1'b0;
      has_outcome = 1'b0;
      outcome     = '0;
      if (stream_done) begin
         if (last) clear_stream();
         return;
      end
      taken = 1'b1;
      for (int k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = value;
      if (bytes_seen != '1) bytes_seen++;
      len = effective_length();
      hit = (bytes_seen >= len);
      // Pattern byte 0 lines up with the oldest byte of the match.
      for (int i = 0; i < len; i++)
         if (hit && care_bits[i] && window[len - 1 - i] != pattern_byte(i)) hit = 1'b0;
      if (hit) begin
         has_outcome    = 1'b1;
         outcome.found  = 1'b1;
         outcome.offset = bytes_seen - len;
         if (last) clear_stream();
         else stream_done = 1'b1;
      end else if (last) begin
         has_outcome = 1'b1;
         clear_stream();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Drop valid and hold until every predicted response has arrived, then
   // let the pipeline settle so dropped bytes are fully retired.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      wait_drained();
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      apply_csr(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Present one byte request; valid stays high on return so back-to-back
   // requests keep it asserted. A typed outcome replaces the prediction.
   task automatic send_byte(input logic [7:0] value, input logic last, input bit typed,
                            input scan_outcome_type typed_outcome, output bit taken);
      bit               has_outcome;
      scan_outcome_type outcome;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.data_byte = value;
      req_if.last_byte = last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      scan_byte(value, last, taken, has_outcome, outcome);
      if (typed) begin
         has_outcome = 1'b1;
         outcome     = typed_outcome;
      end
      if (has_outcome) pending_outcomes.push_back(outcome);
   endtask

   // Response side: stall at random, check each accepted response in order.
   initial begin
      scan_outcome_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            outcomes_seen++;
            if (rsp_if.found === 1'b1) matches_seen++;
            if (pending_outcomes.size() == 0) begin
               $error("unexpected response: found %0d, match_offset %0d",
                      rsp_if.found, rsp_if.match_offset);
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_if.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
                  errors++;
               end
               if (rsp_if.match_offset !== want.offset) begin
                  $error("match_offset: expected %0d, actual %0d",
                         want.offset, rsp_if.match_offset);
                  errors++;
               end
            end
         end
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
      stim_row_type row;
      row        = '{default: '0};
      row.is_csr = 1'b1;
      row.index  = idx;
      row.data   = data;
      directed_rows.push_back(row);
   endtask

   task automatic add_byte(input logic [7:0] value, input logic last);
      stim_row_type row;
      row       = '{default: '0};
      row.value = value;
      row.last  = last;
      directed_rows.push_back(row);
   endtask

   task automatic add_check(input logic [7:0] value, input logic last,
                            input logic found, input logic [OFFSET_OUT_W-1:0] offset);
      stim_row_type row;
      row         = '{default: '0};
      row.value   = value;
      row.last    = last;
      row.typed   = 1'b1;
      row.outcome = '{found: found, offset: offset};
      directed_rows.push_back(row);
   endtask

   // Filler leans on pattern bytes so that accidental matches happen often.
   function automatic logic [7:0] filler_byte();
      if ($urandom_range(1)) return 8'($urandom_range(255));
      return pattern_byte($urandom_range(PATTERN_REG_BYTES - 1));
   endfunction

   // Register setting for one stretch of random buffers; kinds cycle through
   // the length and mask extremes before going fully random.
   task automatic load_setting(input int kind);
      logic [WORD_W-1:0] mask_data;
      logic [WORD_W-1:0] len_data;
      mask_data = {$urandom, $urandom};
      len_data  = {$urandom, $urandom};
      unique case (kind % 6)
         0: len_data[LEN_REG_W-1:0] = 6'd1;
         1: begin
            len_data[LEN_REG_W-1:0]  = 6'd32;
            mask_data[MASK_W-1:0]    = '1;
         end
         2: len_data[LEN_REG_W-1:0] = 6'd0;
         3: len_data[LEN_REG_W-1:0] = 6'($urandom_range(63, 33));
         4: begin
            len_data[LEN_REG_W-1:0]  = 6'($urandom_range(32, 1));
            mask_data[MASK_W-1:0]    = '0;
         end
         default: len_data[LEN_REG_W-1:0] = 6'($urandom_range(63));
      endcase
      csr_write(CSR_PATTERN_WORD_0, {$urandom, $urandom});
      csr_write(CSR_PATTERN_WORD_1, {$urandom, $urandom});
      csr_write(CSR_PATTERN_WORD_2, {$urandom, $urandom});
      csr_write(CSR_PATTERN_WORD_3, {$urandom, $urandom});
      csr_write(CSR_CARE_MASK, mask_data);
      csr_write(CSR_PATTERN_LENGTH, len_data);
      csr_write($urandom_range(1) ? CSR_UNUSED_6 : CSR_UNUSED_7, {$urandom, $urandom});
   endtask

   // One buffer: mostly a planted pattern copy inside random filler, the
   // rest plain noise; short buffers dominate.
   task automatic send_random_buffer();
      logic [7:0] scan_bytes [$];
      int         len;
      int         n;
      int         at;
      bit         taken;
      len = effective_length();
      n   = ($urandom_range(9) == 0) ? $urandom_range(96, 1) : $urandom_range(len + 16, 1);
      for (int j = 0; j < n; j++) scan_bytes.push_back(filler_byte());
      if ($urandom_range(99) < 60 && n >= len) begin
         at = $urandom_range(n - len);
         for (int i = 0; i < len; i++)
            if (care_bits[i]) scan_bytes[at + i] = pattern_byte(i);
      end
      // Now and then hold the sender until the block has caught up.
      if ($urandom_range(19) == 0) wait_drained();
      for (int j = 0; j < n; j++) begin
         send_byte(scan_bytes[j], j == n - 1, 1'b0, '0, taken);
         random_bytes++;
         if (!taken) dropped_bytes++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      bit taken;
      int spins;

      // Drive every input to a known value before the first edge.
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_PATTERN_WORD_0;
      csr_if.data      = '0;

      // Reset values of the predicted registers and stream.
      for (int w = 0; w < N_WORDS; w++) pattern_words[w] = '0;
      care_bits  = '1;
      length_reg = 6'd32;
      clear_stream();

      // Defaults: all-zero pattern, every byte cared for, length 32; a
      // one-byte buffer is shorter than the pattern and reports no match.
      add_check(8'h00, 1'b1, 1'b0, 32'd0);
      // Single-byte pattern 0xFF: the second byte matches, the rest of the
      // buffer is dropped without a response.
      add_csr(CSR_PATTERN_WORD_0, 64'h0000_0000_0000_00FF);
      add_csr(CSR_PATTERN_LENGTH, 64'd1);
      add_byte(8'h00, 1'b0);
      add_check(8'hFF, 1'b0, 1'b1, 32'd1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      // Length zero behaves as one; a match on the last byte still reports.
      add_csr(CSR_PATTERN_LENGTH, 64'd0);
      add_check(8'hFF, 1'b1, 1'b1, 32'd0);
      // Writes to unknown indexes change nothing.
      add_csr(CSR_UNUSED_6, '1);
      add_csr(CSR_UNUSED_7, '1);
      add_check(8'h7E, 1'b1, 1'b0, 32'd0);
      // All wildcards: the third byte completes a three-byte match.
      add_csr(CSR_CARE_MASK, 64'd0);
      add_csr(CSR_PATTERN_LENGTH, 64'd3);
      add_byte(8'h11, 1'b0);
      add_byte(8'h22, 1'b0);
      add_check(8'h33, 1'b0, 1'b1, 32'd0);
      add_byte(8'h44, 1'b1);
      // Length past the window clips to 32; two bytes cannot match.
      add_csr(CSR_PATTERN_LENGTH, 64'd63);
      add_byte(8'hAA, 1'b0);
      add_check(8'h55, 1'b1, 1'b0, 32'd0);
      // Only pattern byte 8 cared for, from the second word.
      add_csr(CSR_PATTERN_WORD_1, 64'hFFFF_FFFF_FFFF_FFC3);
      add_csr(CSR_CARE_MASK, 64'h0000_0000_0000_0100);
      add_csr(CSR_PATTERN_LENGTH, 64'd9);
      for (int j = 0; j < 8; j++) add_byte(j[0] ? 8'hFF : 8'h00, 1'b0);
      add_check(8'hC3, 1'b1, 1'b1, 32'd0);

      // Hold reset, then release it on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_csr) begin
            csr_write(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_byte(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].outcome, taken);
            directed_bytes++;
         end
      end

      // Random part: three idle profiles, four register settings each.
      for (int mode = 0; mode < 3; mode++) begin
         unique case (mode)
            0: begin send_idle_pct = 32; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int s = 0; s < 4; s++) begin
            load_setting(mode * 4 + s);
            while (random_bytes < (mode * 4 + s + 1) * PER_SETTING) send_random_buffer();
         end
      end

      // Drop valid, wait for the last responses with a bound, then settle.
      @(negedge clock);
      req_if.valid = 1'b0;
      spins = 0;
      while (pending_outcomes.size() != 0 && spins < 5000) begin
         @(negedge clock);
         spins++;
      end
      repeat (DRAIN_CYCLES * 4) @(negedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d predicted responses never arrived", pending_outcomes.size());
         errors++;
      end

      $display("Sent %0d directed and %0d random byte requests (%0d dropped after a match)",
               directed_bytes, random_bytes, dropped_bytes);
      $display("over %0d register writes; checked %0d responses, %0d matches, %0d errors.",
               csr_writes, outcomes_seen, matches_seen, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
